FILE: rtl/dmm_pkg.sv
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared types and constants for the dense matrix multiply engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dmm_pkg;

  localparam int IDX_W  = 6;   // row / col index width
  localparam int SIZE_W = 7;   // matrix_size register width
  localparam int VAL_W  = 16;  // Q8.8 element
  localparam int PROD_W = 32;  // Q16.16 single product
  localparam int SUM_W  = 38;  // Q22.16 accumulated result

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 38'sd68719476736;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -38'sd68719476736;

  typedef enum logic [1:0] {
    MODE_WR_A = 2'd0,
    MODE_WR_B = 2'd1,
    MODE_RD_C = 2'd2
  } mode_t;

  // Per-step control that rides alongside the store read data.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage : dmm_pkg

`default_nettype wire

FILE: rtl/dense_matrix_multiply_top.sv
// Sequence: an element write goes into its store on accept; a product read walks
//   n k steps (n = active size), then multiply, accumulate, sequencer hand-off,
//   output register; an out-of-range read skips to the output register.
// Flow: one item at a time; a read holds the input until its product is registered,
//   set by the shared multiply-accumulate unit and the one read port per store.
// Reset: synchronous, active low; matrix_size returns to 64, stores are not
//   cleared (entries are undefined until written).
// ----------------------------------------------------------------------------
// dense_matrix_multiply_top
// Square matrix multiply engine: A and B element stores, product readout.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_matrix_multiply_top #(
  parameter int MAX_DIM = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [dmm_pkg::SIZE_W-1:0]           cfg_matrix_size,
  // input words
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           in_mode,
  input  wire logic [dmm_pkg::IDX_W-1:0]            in_row,
  input  wire logic [dmm_pkg::IDX_W-1:0]            in_col,
  input  wire logic signed [dmm_pkg::VAL_W-1:0]     in_value,
  // result words
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [dmm_pkg::SUM_W-1:0]          out_product_sum,
  output logic                                      out_index_error
);

  import dmm_pkg::*;

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = $clog2(DEPTH);
  // Largest size the 7-bit register can ask for, capped at the store dimension.
  localparam int DIM_CAP = (MAX_DIM > 127) ? 127 : MAX_DIM;
  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(DIM_CAP);
  localparam logic [AW-1:0]     DIM_A    = AW'(MAX_DIM);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DELIVER
  } state_t;

  state_t                    state_r;
  logic [SIZE_W-1:0]         size_r;
  logic [IDX_W-1:0]          row_r, col_r;
  logic [SIZE_W-1:0]         k_r;
  logic                      err_r;
  logic                      out_valid_r;
  logic signed [SUM_W-1:0]   out_sum_r;
  logic                      out_err_r;

  // ---- size and range check ----
  logic [SIZE_W-1:0] size_act;
  logic              in_bad;

  assign size_act = (size_r > SIZE_CAP) ? SIZE_CAP : size_r;
  assign in_bad   = ({1'b0, in_row} >= size_act) || ({1'b0, in_col} >= size_act);

  // ---- input accept and store writes ----
  logic  in_fire;
  mode_t in_mode_c;
  logic  wr_a, wr_b;
  logic [AW-1:0] wr_addr;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign in_mode_c = mode_t'(in_mode);
  assign wr_a      = in_fire && !in_bad && (in_mode_c == MODE_WR_A);
  assign wr_b      = in_fire && !in_bad && (in_mode_c == MODE_WR_B);
  // Truncation is harmless: an accepted write index is below MAX_DIM.
  assign wr_addr   = AW'(in_row) * DIM_A + AW'(in_col);

  // ---- k walk: A[row][k] and B[k][col] ----
  logic [AW-1:0] rd_addr_a, rd_addr_b;
  logic          k_last;
  mac_ctrl_t     mac_ctrl;

  assign rd_addr_a = AW'(row_r) * DIM_A + AW'(k_r);
  assign rd_addr_b = AW'(k_r) * DIM_A + AW'(col_r);
  assign k_last    = (k_r == size_act - SIZE_W'(1));

  always_comb begin
    mac_ctrl.valid = (state_r == ST_ISSUE);
    mac_ctrl.first = (k_r == '0);
    mac_ctrl.last  = k_last;
  end

  logic [VAL_W-1:0] a_rd, b_rd;

  dmm_store #(.DEPTH(DEPTH), .AW(AW), .DW(VAL_W)) u_store_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_addr (rd_addr_a),
    .rd_data (a_rd)
  );

  dmm_store #(.DEPTH(DEPTH), .AW(AW), .DW(VAL_W)) u_store_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_addr (rd_addr_b),
    .rd_data (b_rd)
  );

  logic                    mac_done;
  logic signed [SUM_W-1:0] mac_sum;

  dmm_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl_in (mac_ctrl),
    .a_data  (a_rd),
    .b_data  (b_rd),
    .done    (mac_done),
    .sum     (mac_sum)
  );

  // ---- output slot free this cycle ----
  logic out_room;
  assign out_room = !out_valid_r || !out_stall;

  // ---- configuration register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_matrix_size;
    end
  end

  // ---- sequencer and output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      err_r       <= 1'b0;
    end else begin
      // the deliver state decides the output slot on its own
      if (out_valid_r && !out_stall && (state_r != ST_DELIVER)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && (in_mode_c == MODE_RD_C)) begin
            row_r <= in_row;
            col_r <= in_col;
            k_r   <= '0;
            err_r <= in_bad;
            // out-of-range read skips the walk and reports zero
            state_r <= in_bad ? ST_DELIVER : ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          k_r <= k_r + SIZE_W'(1);
          if (k_last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (mac_done) begin
            state_r <= ST_DELIVER;
          end
        end
        ST_DELIVER: begin
          if (out_room) begin
            out_valid_r     <= 1'b1;
            out_sum_r       <= err_r ? '0 : mac_sum;
            out_err_r       <= err_r;
            state_r         <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_product_sum = out_sum_r;
  assign out_index_error = out_err_r;

endmodule : dense_matrix_multiply_top

`default_nettype wire

FILE: rtl/dmm_store.sv
// ----------------------------------------------------------------------------
// dmm_store
// Single-port-write, single-port-read synchronous element memory.
// ----------------------------------------------------------------------------
`default_nettype none

module dmm_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule : dmm_store

`default_nettype wire

FILE: rtl/dmm_mac.sv
// ----------------------------------------------------------------------------
// dmm_mac
// Registered multiply then accumulate, with saturated Q22.16 output.
// ----------------------------------------------------------------------------
`default_nettype none

module dmm_mac (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire dmm_pkg::mac_ctrl_t                      ctrl_in,   // aligned with addresses
  input  wire logic signed [dmm_pkg::VAL_W-1:0]        a_data,    // arrives the cycle after ctrl_in
  input  wire logic signed [dmm_pkg::VAL_W-1:0]        b_data,
  output logic                                         done,
  output logic signed [dmm_pkg::SUM_W-1:0]             sum
);

  import dmm_pkg::*;

  mac_ctrl_t                 ctrl_d1_r, ctrl_d2_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [SUM_W-1:0]   acc_r, acc_nxt;
  logic                      done_r;

  always_comb begin
    if (ctrl_d2_r.first) begin
      acc_nxt = SUM_W'(prod_r);
    end else begin
      acc_nxt = acc_r + SUM_W'(prod_r);
    end
  end

  // control pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_d1_r <= '0;
      ctrl_d2_r <= '0;
      done_r    <= 1'b0;
    end else begin
      ctrl_d1_r <= ctrl_in;
      ctrl_d2_r <= ctrl_d1_r;
      done_r    <= ctrl_d2_r.valid && ctrl_d2_r.last;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctrl_d1_r.valid) begin
      prod_r <= a_data * b_data;
    end
    if (ctrl_d2_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;

  always_comb begin
    if (acc_r > SUM_MAX) begin
      sum = SUM_MAX;
    end else if (acc_r < SUM_MIN) begin
      sum = SUM_MIN;
    end else begin
      sum = acc_r;
    end
  end

endmodule : dmm_mac

`default_nettype wire
